// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the deframer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SLC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Types, codes and the CRC step shared by the deframer modules
// ----------------------------------------------------------------------------
package slc_pkg;

  // result status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_READY   = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

  // framing constants
  localparam logic [7:0]  SYNC_RESET   = 8'hAA;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  LEN_MIN      = 8'd9;
  localparam logic [7:0]  LEN_OVERHEAD = 8'd11;
  localparam logic [7:0]  LEN_TRIM     = 8'd2;
  localparam logic [7:0]  PAY_BASE     = 8'd9;
  localparam logic [7:0]  HDR_LAST     = 8'd8;
  localparam int          HDR_BYTES    = 8;

  // commands from controller to datapath
  typedef struct packed {
    logic       len_load;
    logic       body_load;
    logic       crc_hi_load;
    logic       out_status;
    logic [1:0] status_code;
    logic       out_frame_empty;
    logic       emit_start;
    logic       emit_read;
    logic       emit_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic len_short;
    logic body_done;
    logic frame_good;
    logic plen_zero;
    logic emit_last;
    logic out_free;
  } sts_t;

  // one byte of crc-16/xmodem, msb first
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/slc_ram.sv =====
// ----------------------------------------------------------------------------
// slc_ram
// Generic single-port-write, single-port-read RAM with registered read
// ----------------------------------------------------------------------------
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/slc_datapath.sv =====
// ----------------------------------------------------------------------------
// slc_datapath
// Sync registers, length/crc tracking, header and payload storage, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slc_datapath #(
  parameter int MAX_PAYLOAD = 32,
  parameter int LEN_W = $clog2(MAX_PAYLOAD + 1),
  parameter int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic [7:0]                   rx_byte,
  input  slc_pkg::cmd_t                cmd,
  output slc_pkg::sts_t                sts,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [1:0]                   status,
  output logic [7:0]                   src_subnet,
  output logic [7:0]                   src_device,
  output logic [15:0]                  device_type,
  output logic [15:0]                  operation_code,
  output logic [7:0]                   dst_subnet,
  output logic [7:0]                   dst_device,
  output logic [LEN_W-1:0]             payload_length,
  output logic                         payload_valid,
  output logic [7:0]                   payload_byte,
  output logic [IDX_W-1:0]             payload_index,
  output logic                         last
);

  import slc_pkg::*;

  localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

  logic [7:0]       sync_first;
  logic [7:0]       sync_second;
  logic [7:0]       byte_count;
  logic [7:0]       expected_length;
  logic [15:0]      running_crc;
  logic [7:0]       crc_hi;
  logic [7:0]       hdr [HDR_BYTES];
  logic [IDX_W-1:0] emit_idx;
  logic [7:0]       plen;
  logic [7:0]       plen_m1;
  logic [7:0]       pl_off;
  logic [2:0]       hdr_addr;
  logic             hdr_wr;
  logic             pl_wr;
  logic [7:0]       ram_rd_data;
  logic             any_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_RESET;
      sync_second <= SYNC_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
      endcase
    end
  end

  // length, byte count and crc tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      expected_length <= '0;
      running_crc     <= '0;
      crc_hi          <= '0;
    end else begin
      if (cmd.len_load) begin
        expected_length <= rx_byte;
        byte_count      <= 8'd1;
        running_crc     <= crc16_step(16'h0000, rx_byte);
      end else if (cmd.body_load) begin
        byte_count  <= byte_count + 8'd1;
        running_crc <= crc16_step(running_crc, rx_byte);
      end
      if (cmd.crc_hi_load) begin
        crc_hi <= rx_byte;
      end
    end
  end

  // header and payload write decode
  assign hdr_addr = 3'(byte_count - 8'd1);
  assign hdr_wr   = cmd.body_load && (byte_count != 8'd0) && (byte_count <= HDR_LAST);
  assign pl_off   = byte_count - PAY_BASE;
  assign pl_wr    = cmd.body_load && (byte_count >= PAY_BASE) && (pl_off < MAX_B);

  // header bytes
  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr[hdr_addr] <= rx_byte;
    end
  end

  // payload store
  slc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (pl_wr),
    .wr_addr (pl_off[IDX_W-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.emit_read),
    .rd_addr (emit_idx),
    .rd_data (ram_rd_data)
  );

  // payload emission index
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (cmd.emit_start) begin
      emit_idx <= '0;
    end else if (cmd.emit_load) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // frame checks
  assign plen    = expected_length - LEN_OVERHEAD;
  assign plen_m1 = plen - 8'd1;

  always_comb begin
    sts.sync1_hit  = (rx_byte == sync_first);
    sts.sync2_hit  = (rx_byte == sync_second);
    sts.len_short  = (rx_byte < LEN_MIN);
    sts.body_done  = ((byte_count + 8'd1) == (expected_length - LEN_TRIM));
    sts.frame_good = ({crc_hi, rx_byte} == running_crc) && (plen <= MAX_B);
    sts.plen_zero  = (plen == 8'd0);
    sts.emit_last  = (emit_idx == plen_m1[IDX_W-1:0]);
    sts.out_free   = !res_valid || !res_stall;
  end

  // result register valid
  assign any_load = cmd.out_status || cmd.out_frame_empty || cmd.emit_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (any_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.out_status) begin
      status         <= cmd.status_code;
      src_subnet     <= '0;
      src_device     <= '0;
      device_type    <= '0;
      operation_code <= '0;
      dst_subnet     <= '0;
      dst_device     <= '0;
      payload_length <= '0;
      payload_valid  <= 1'b0;
      payload_byte   <= '0;
      payload_index  <= '0;
      last           <= 1'b1;
    end else if (cmd.out_frame_empty || cmd.emit_load) begin
      status         <= ST_READY;
      src_subnet     <= hdr[0];
      src_device     <= hdr[1];
      device_type    <= {hdr[2], hdr[3]};
      operation_code <= {hdr[4], hdr[5]};
      dst_subnet     <= hdr[6];
      dst_device     <= hdr[7];
      payload_length <= plen[LEN_W-1:0];
      payload_valid  <= cmd.emit_load;
      payload_byte   <= cmd.emit_load ? ram_rd_data : 8'h00;
      payload_index  <= cmd.emit_load ? emit_idx : '0;
      last           <= cmd.emit_load ? sts.emit_last : 1'b1;
    end
  end

  // checks
  `SLC_ASSERT_IMP(a_index_in_length, clk, rst, res_valid && payload_valid, (payload_index < payload_length), "payload index beyond payload length")
  `SLC_ASSERT_IMP(a_status_single, clk, rst, res_valid && (status != ST_READY), last && !payload_valid, "status result not a single closing result")

endmodule

// ===== rtl/slc_ctrl.sv =====
// ----------------------------------------------------------------------------
// slc_ctrl
// Frame parsing and payload emission state machine
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_valid,
  output logic          rx_stall,
  output slc_pkg::cmd_t cmd,
  input  slc_pkg::sts_t sts
);

  import slc_pkg::*;

  localparam logic [2:0] S_HUNT1   = 3'd0;
  localparam logic [2:0] S_HUNT2   = 3'd1;
  localparam logic [2:0] S_LEN     = 3'd2;
  localparam logic [2:0] S_BODY    = 3'd3;
  localparam logic [2:0] S_CRC_HI  = 3'd4;
  localparam logic [2:0] S_CRC_LO  = 3'd5;
  localparam logic [2:0] S_EMIT_RD = 3'd6;
  localparam logic [2:0] S_EMIT_LD = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       emitting;
  logic       accept;

  // input handshake
  assign emitting = (state == S_EMIT_RD) || (state == S_EMIT_LD);
  assign rx_stall = emitting || !sts.out_free;
  assign accept   = rx_valid && !rx_stall;

  // next state and commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = ST_NONE;
    unique case (state)
      S_HUNT1: begin
        if (accept) begin
          cmd.out_status = 1'b1;
          if (sts.sync1_hit) begin
            state_next = S_HUNT2;
          end
        end
      end
      S_HUNT2: begin
        if (accept) begin
          cmd.out_status = 1'b1;
          if (sts.sync2_hit) begin
            state_next = S_LEN;
          end else if (!sts.sync1_hit) begin
            state_next = S_HUNT1;
          end
        end
      end
      S_LEN: begin
        if (accept) begin
          cmd.out_status = 1'b1;
          if (sts.len_short) begin
            cmd.status_code = ST_INVALID;
            state_next      = S_HUNT1;
          end else begin
            cmd.status_code = ST_BUSY;
            cmd.len_load    = 1'b1;
            state_next      = S_BODY;
          end
        end
      end
      S_BODY: begin
        if (accept) begin
          cmd.out_status  = 1'b1;
          cmd.status_code = ST_BUSY;
          cmd.body_load   = 1'b1;
          if (sts.body_done) begin
            state_next = S_CRC_HI;
          end
        end
      end
      S_CRC_HI: begin
        if (accept) begin
          cmd.out_status  = 1'b1;
          cmd.status_code = ST_BUSY;
          cmd.crc_hi_load = 1'b1;
          state_next      = S_CRC_LO;
        end
      end
      S_CRC_LO: begin
        if (accept) begin
          state_next = S_HUNT1;
          priority if (!sts.frame_good) begin
            cmd.out_status  = 1'b1;
            cmd.status_code = ST_INVALID;
          end else if (sts.plen_zero) begin
            cmd.out_frame_empty = 1'b1;
          end else begin
            cmd.emit_start = 1'b1;
            state_next     = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        state_next    = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_next    = sts.emit_last ? S_HUNT1 : S_EMIT_RD;
        end
      end
      default: state_next = S_HUNT1;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT1;
    end else begin
      state <= state_next;
    end
  end

  // checks
  `SLC_ASSERT_IMP(a_load_into_free_slot, clk, rst, cmd.out_status || cmd.out_frame_empty || cmd.emit_load, sts.out_free, "result loaded into an occupied output register")
  `SLC_ASSERT_NXT(a_read_before_load, clk, rst, cmd.emit_read, state == S_EMIT_LD, "payload read not followed by load state")
  `SLC_ASSERT_IMP(a_emit_from_crc, clk, rst, cmd.emit_start, accept && (state == S_CRC_LO), "emission started outside crc check")

endmodule

// ===== rtl/sync_length_crc_deframer_top.sv =====
// ----------------------------------------------------------------------------
// sync_length_crc_deframer_top
// Byte-stream deframer: two sync bytes, a length byte, header and payload
// bytes, then a big-endian CRC-16/XMODEM over length, header and payload.
// One received byte is taken per clock while the result side keeps up; each
// byte but the closing CRC byte of a good frame gives one status transaction,
// registered and offered on the next cycle. A checked frame with n payload
// bytes gives n result transactions (one if n is zero); during that run the
// receive side is stalled and each payload byte is read from the RAM in
// S_EMIT_RD and loaded into the result register in S_EMIT_LD once it is free.
// A result held in the output register by a result stall stalls the receive
// side too; the next byte is taken in the same cycle as the result leaves.
// ----------------------------------------------------------------------------
module sync_length_crc_deframer_top #(
  parameter int MAX_PAYLOAD = 32,
  parameter int LEN_W = $clog2(MAX_PAYLOAD + 1),
  parameter int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          rx_valid,
  output logic                          rx_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [1:0]                    status,
  output logic [7:0]                    src_subnet,
  output logic [7:0]                    src_device,
  output logic [15:0]                   device_type,
  output logic [15:0]                   operation_code,
  output logic [7:0]                    dst_subnet,
  output logic [7:0]                    dst_device,
  output logic [LEN_W-1:0]              payload_length,
  output logic                          payload_valid,
  output logic [7:0]                    payload_byte,
  output logic [IDX_W-1:0]              payload_index,
  output logic                          last
);

  import slc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // frame controller
  slc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath and result register
  slc_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .LEN_W       (LEN_W),
    .IDX_W       (IDX_W)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .src_subnet     (src_subnet),
    .src_device     (src_device),
    .device_type    (device_type),
    .operation_code (operation_code),
    .dst_subnet     (dst_subnet),
    .dst_device     (dst_device),
    .payload_length (payload_length),
    .payload_valid  (payload_valid),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .last           (last)
  );

endmodule
